// ----- rtl/satm_pkg.sv -----
package satm_pkg;

  localparam int SENSOR_W = 16;
  localparam int ROOM_W   = 16;
  localparam int TEMP_W   = 16;
  localparam int STAMP_W  = 32;
  localparam int STATUS_W = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [STATUS_W-1:0] {
    ST_LOADED    = 3'd0,
    ST_FULL      = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_UNKNOWN   = 3'd3,
    ST_UPDATED   = 3'd4
  } status_t;

  localparam logic [CFG_IDX_W-1:0] REG_COLD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd2;

  localparam logic signed [TEMP_W-1:0] COLD_RESET = 16'sd4352;
  localparam logic signed [TEMP_W-1:0] HOT_RESET  = 16'sd6144;
  localparam logic [CFG_DATA_W-1:0] TIMEOUT_RESET = 16'd60;

  // Command applied to the whole chain; every cell sees it in the same cycle.
  typedef struct packed {
    logic                 load;     // append at the first free cell
    logic                 touch;    // write stamp and sample to the hit cell
    logic [SENSOR_W-1:0]  sensor;
    logic [ROOM_W-1:0]    room;
    logic [TEMP_W-1:0]    temp;
    logic [STAMP_W-1:0]   stamp;
    logic [CFG_DATA_W-1:0] timeout;
  } chain_cmd_t;

endpackage

// ----- rtl/satm_cell.sv -----
// One table entry: map data, last stamp and its private averaging window.
// Compaction copies the contents of the upper neighbour into this cell.
module satm_cell #(
  parameter int WINDOW_LEN = 5,
  parameter int WIN_W = 3,
  parameter int DATA_W = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  satm_pkg::chain_cmd_t  cmd,
  input  logic                  load_here,
  input  logic                  touch_here,
  input  logic                  shift_in,   // take the upper neighbour's contents
  input  logic [DATA_W-1:0]     up_data,
  input  logic                  up_valid,
  output logic [DATA_W-1:0]     data,
  output logic                  valid,
  output logic                  stale
);
  import satm_pkg::*;

  // Packed contents: window samples, next pointer, fill, stamp, room, sensor.
  localparam int SEN_LO = 0;
  localparam int ROOM_LO = SEN_LO + SENSOR_W;
  localparam int STAMP_LO = ROOM_LO + ROOM_W;
  localparam int FILL_LO = STAMP_LO + STAMP_W;
  localparam int NEXT_LO = FILL_LO + WIN_W;
  localparam int WIN_LO = NEXT_LO + WIN_W;

  logic [STAMP_W-1:0] stamp_q;
  logic [WIN_W-1:0] pos, pos_inc, fill_q;
  logic [DATA_W-1:0] data_next;
  logic signed [STAMP_W:0] age;

  assign stamp_q = data[STAMP_LO +: STAMP_W];
  assign fill_q = data[FILL_LO +: WIN_W];
  assign pos = (data[NEXT_LO +: WIN_W] >= WIN_W'(WINDOW_LEN)) ? '0 : data[NEXT_LO +: WIN_W];
  assign pos_inc = (pos + 1'b1 >= WIN_W'(WINDOW_LEN)) ? '0 : WIN_W'(pos + 1'b1);
  assign age = $signed({1'b0, cmd.stamp}) - $signed({1'b0, stamp_q});
  assign stale = valid && (stamp_q != '0) && (age > $signed({17'd0, cmd.timeout}));

  always_comb begin
    data_next = data;
    if (touch_here) begin
      data_next[STAMP_LO +: STAMP_W] = cmd.stamp;
      data_next[WIN_LO + int'(pos)*TEMP_W +: TEMP_W] = cmd.temp;
      data_next[NEXT_LO +: WIN_W] = pos_inc;
      if (fill_q < WIN_W'(WINDOW_LEN)) begin
        data_next[FILL_LO +: WIN_W] = fill_q + 1'b1;
      end
    end else if (load_here) begin
      data_next[SEN_LO +: SENSOR_W] = cmd.sensor;
      data_next[ROOM_LO +: ROOM_W] = cmd.room;
      data_next[STAMP_LO +: STAMP_W] = '0;
      data_next[FILL_LO +: WIN_W] = '0;
      data_next[NEXT_LO +: WIN_W] = '0;
    end else if (shift_in) begin
      data_next = up_data;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
    if (rst) begin
      valid <= 1'b0;
    end else if (load_here) begin
      valid <= 1'b1;
    end else if (shift_in) begin
      valid <= up_valid;
    end
  end

endmodule

// ----- rtl/satm_div.sv -----
// Signed restoring divider for the window average, one quotient bit a cycle.
module satm_div #(
  parameter int DEN_W = 3
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic signed [31:0]          num,
  input  logic [DEN_W-1:0]            den,
  output logic                        done,
  output logic signed [15:0]          quot
);
  import satm_pkg::*;

  logic [31:0] q;
  logic [DEN_W:0] r;
  logic [5:0] cnt;
  logic busy, neg;
  logic [DEN_W:0] r_sh;
  logic [31:0] qn;

  assign r_sh = {r[DEN_W-1:0], q[31]};
  assign qn = neg ? (~q + 1'b1) : q;
  assign quot = qn[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
        neg <= num[31];
        q <= num[31] ? 32'(-num) : 32'(num);
        r <= '0;
      end else if (busy) begin
        if (r_sh >= {1'b0, den}) begin
          r <= r_sh - {1'b0, den};
          q <= {q[30:0], 1'b1};
        end else begin
          r <= r_sh;
          q <= {q[30:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/sensor_average_threshold_monitor_core.sv -----
// Sensor-to-room table with a per-entry five-sample moving average and cold and
// hot alarms. The table is a row of MAP_DEPTH cells; purging removes one stale
// entry per cycle by shifting the cells above it down. A measurement's result
// follows the purge, the lookup walk, the window sum and the bit-serial divider;
// an unknown sensor answers after the purge and the lookup walk, and a load or a
// dropped duplicate on the cycle after acceptance.
// One item is in flight at a time; the next word is taken only once the result
// word has left the output register.
module sensor_average_threshold_monitor_core #(
  parameter int MAP_DEPTH = 32,
  parameter int WINDOW_LEN = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata: cmd[0], sensor[16:1], room[32:17], temperature[48:33],
  // timestamp[80:49], zero fill to 88 bits
  input  logic [87:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata: status[2:0], room[18:3], average[34:19], too_cold[35], too_hot[36],
  // zero fill to 40 bits
  output logic [39:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [satm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [satm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import satm_pkg::*;

  localparam int IDX_W = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int CNT_W = $clog2(MAP_DEPTH + 1);
  localparam int WIN_W = $clog2(WINDOW_LEN + 1);
  localparam int WIX_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int DATA_W = SENSOR_W + ROOM_W + STAMP_W + 2*WIN_W + WINDOW_LEN*TEMP_W;
  localparam int FILL_LO = SENSOR_W + ROOM_W + STAMP_W;
  localparam int WIN_LO = FILL_LO + 2*WIN_W;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_PURGE  = 7'b0000010,
    S_FIND   = 7'b0000100,
    S_SUM    = 7'b0001000,
    S_DIV    = 7'b0010000,
    S_WAIT   = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  state_t state;
  logic signed [TEMP_W-1:0] cold_limit, hot_limit;
  logic [CFG_DATA_W-1:0] idle_timeout;
  logic [SENSOR_W-1:0] prev_sensor;
  logic [STAMP_W-1:0] prev_stamp;
  logic prev_valid;
  logic [CNT_W-1:0] map_used;
  chain_cmd_t cmd;

  logic [DATA_W-1:0] cell_data [MAP_DEPTH];
  logic [MAP_DEPTH-1:0] cell_valid, cell_stale, shift_en, load_en, touch_en;
  logic [IDX_W-1:0] stale_idx, scan, hit;
  logic any_stale, found;
  logic [WIX_W-1:0] k;
  logic signed [31:0] sum;
  logic [WIN_W-1:0] fill;
  logic div_start, div_done;
  logic signed [15:0] quot;
  logic [DATA_W-1:0] hit_data;

  assign s_tready = (state == S_IDLE) && !m_tvalid;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cold_limit <= COLD_RESET;
      hot_limit <= HOT_RESET;
      idle_timeout <= TIMEOUT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_COLD:    cold_limit <= cfg_data;
        REG_HOT:     hot_limit <= cfg_data;
        REG_TIMEOUT: idle_timeout <= cfg_data;
        default: ;
      endcase
    end
  end

  // Lowest stale cell; everything above it moves down one place.
  always_comb begin
    any_stale = 1'b0;
    stale_idx = '0;
    for (int i = MAP_DEPTH-1; i >= 0; i--) begin
      if (cell_stale[i]) begin
        any_stale = 1'b1;
        stale_idx = IDX_W'(i);
      end
    end
  end

  // The table count has already been raised when the load strobe is seen.
  always_comb begin
    for (int i = 0; i < MAP_DEPTH; i++) begin
      shift_en[i] = (state == S_PURGE) && any_stale && (IDX_W'(i) >= stale_idx);
      load_en[i] = cmd.load && (CNT_W'(i + 1) == map_used);
      touch_en[i] = cmd.touch && (IDX_W'(i) == hit);
    end
  end

  for (genvar g = 0; g < MAP_DEPTH; g++) begin : g_cell
    logic [DATA_W-1:0] up_d;
    logic up_v;
    if (g == MAP_DEPTH-1) begin : g_top
      assign up_d = cell_data[g];
      assign up_v = 1'b0;
    end else begin : g_mid
      assign up_d = cell_data[g+1];
      assign up_v = cell_valid[g+1];
    end
    satm_cell #(.WINDOW_LEN(WINDOW_LEN), .WIN_W(WIN_W), .DATA_W(DATA_W)) u_cell (
      .clk, .rst, .cmd,
      .load_here(load_en[g]), .touch_here(touch_en[g]), .shift_in(shift_en[g]),
      .up_data(up_d), .up_valid(up_v),
      .data(cell_data[g]), .valid(cell_valid[g]), .stale(cell_stale[g])
    );
  end

  assign hit_data = cell_data[hit];
  assign fill = hit_data[FILL_LO +: WIN_W];

  satm_div #(.DEN_W(WIN_W)) u_div (
    .clk, .rst, .start(div_start), .num(sum), .den(fill), .done(div_done), .quot
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_tvalid <= 1'b0;
      prev_valid <= 1'b0;
      prev_sensor <= '0;
      prev_stamp <= '0;
      map_used <= '0;
      cmd.load <= 1'b0;
      cmd.touch <= 1'b0;
      div_start <= 1'b0;
    end else begin
      cmd.load <= 1'b0;
      cmd.touch <= 1'b0;
      div_start <= 1'b0;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            cmd.sensor <= s_tdata[16:1];
            cmd.room <= s_tdata[32:17];
            cmd.temp <= s_tdata[48:33];
            cmd.stamp <= s_tdata[80:49];
            cmd.timeout <= idle_timeout;
            if (!s_tdata[0]) begin
              if (map_used >= CNT_W'(MAP_DEPTH)) begin
                m_tdata <= {37'd0, ST_FULL};
              end else begin
                m_tdata <= {37'd0, ST_LOADED};
                cmd.load <= 1'b1;
                map_used <= map_used + 1'b1;
              end
              m_tvalid <= 1'b1;
            end else if (prev_valid && s_tdata[16:1] == prev_sensor &&
                         s_tdata[80:49] == prev_stamp) begin
              m_tdata <= {37'd0, ST_DUPLICATE};
              m_tvalid <= 1'b1;
            end else begin
              prev_valid <= 1'b1;
              prev_sensor <= s_tdata[16:1];
              prev_stamp <= s_tdata[80:49];
              state <= S_PURGE;
            end
          end
        end
        S_PURGE: begin
          if (any_stale) begin
            map_used <= map_used - 1'b1;
          end else begin
            scan <= '0;
            found <= 1'b0;
            state <= S_FIND;
          end
        end
        S_FIND: begin
          if (cell_valid[scan] && cell_data[scan][SENSOR_W-1:0] == cmd.sensor) begin
            hit <= scan;
            found <= 1'b1;
          end
          if (scan == IDX_W'(MAP_DEPTH-1)) begin
            state <= S_SUM;
            k <= '0;
            sum <= '0;
          end else begin
            scan <= scan + 1'b1;
          end
        end
        S_SUM: begin
          if (!found) begin
            m_tdata <= {37'd0, ST_UNKNOWN};
            m_tvalid <= 1'b1;
            state <= S_IDLE;
          end else begin
            cmd.touch <= 1'b1;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          // The window write lands at the end of the first cycle here; from the
          // next cycle on the filled slots are added one a cycle.
          if (!cmd.touch) begin
            if (WIN_W'(k) < fill) begin
              sum <= sum + 32'(signed'(hit_data[WIN_LO + int'(k)*TEMP_W +: TEMP_W]));
            end
            if (k == WIX_W'(WINDOW_LEN-1)) begin
              div_start <= 1'b1;
              state <= S_WAIT;
            end else begin
              k <= k + 1'b1;
            end
          end
        end
        S_WAIT: begin
          if (div_done) begin
            m_tdata <= {3'd0, quot > hot_limit, quot < cold_limit, quot,
                        hit_data[SENSOR_W +: ROOM_W], ST_UPDATED};
            state <= S_OUT;
          end
        end
        S_OUT: begin
          m_tvalid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_used_range: assert property (@(posedge clk) disable iff (rst)
    map_used <= CNT_W'(MAP_DEPTH)) else $error("table count beyond depth");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !s_tready) else $error("input taken while busy");
  a_div_end: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_WAIT) else $error("divider done out of turn");

endmodule

// ----- tb/tb_sensor_average_threshold_monitor_core.sv -----
module tb_sensor_average_threshold_monitor_core;
  timeunit 1ns;
  timeprecision 1ps;
  import satm_pkg::*;

  localparam int DEPTH = 32;
  localparam int WIN   = 5;
  localparam int N_RANDOM = 800;

  typedef struct packed {
    logic [STAMP_W-1:0]  stamp;
    logic [TEMP_W-1:0]   temp;
    logic [ROOM_W-1:0]   room;
    logic [SENSOR_W-1:0] sensor;
    logic                cmd;
  } sensor_word_t;

  typedef struct packed {
    logic                 hot;
    logic                 cold;
    logic [TEMP_W-1:0]    avg;
    logic [ROOM_W-1:0]    room;
    logic [STATUS_W-1:0]  status;
  } alarm_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [87:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  sensor_average_threshold_monitor_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Shadow copy of the sensor table and its averaging windows.
  logic signed [TEMP_W-1:0] lim_cold, lim_hot;
  logic [15:0]              lim_timeout;
  logic [SENSOR_W-1:0] tbl_sensor [DEPTH];
  logic [ROOM_W-1:0]   tbl_room   [DEPTH];
  logic [STAMP_W-1:0]  tbl_seen   [DEPTH];
  logic signed [TEMP_W-1:0] tbl_win [DEPTH][WIN];
  int tbl_next [DEPTH];
  int tbl_fill [DEPTH];
  int tbl_used;
  logic [SENSOR_W-1:0] last_sensor;
  logic [STAMP_W-1:0]  last_stamp;
  bit last_ok;

  sensor_word_t pending_q[$];
  alarm_word_t  alarm_q[$];
  bit hold_send = 1'b0;
  bit calm = 1'b0;
  int n_sent = 0, n_recv = 0, n_bad = 0;
  int status_seen [8];

  function automatic alarm_word_t predict_alarm(sensor_word_t w);
    alarm_word_t r;
    int wr, hit, sum;
    longint age;
    r = '0;
    if (w.cmd == 1'b0) begin
      if (tbl_used >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        tbl_sensor[tbl_used] = w.sensor;
        tbl_room[tbl_used] = w.room;
        tbl_seen[tbl_used] = '0;
        tbl_next[tbl_used] = 0;
        tbl_fill[tbl_used] = 0;
        tbl_used++;
        r.status = ST_LOADED;
      end
    end else if (last_ok && w.sensor == last_sensor && w.stamp == last_stamp) begin
      r.status = ST_DUPLICATE;
    end else begin
      last_ok = 1'b1;
      last_sensor = w.sensor;
      last_stamp = w.stamp;
      // Stale entries go; the survivors close up and keep their order.
      wr = 0;
      for (int i = 0; i < tbl_used; i++) begin
        age = longint'(w.stamp) - longint'(tbl_seen[i]);
        if (!(tbl_seen[i] != 0 && age > longint'(lim_timeout))) begin
          tbl_sensor[wr] = tbl_sensor[i];
          tbl_room[wr] = tbl_room[i];
          tbl_seen[wr] = tbl_seen[i];
          for (int k = 0; k < WIN; k++) tbl_win[wr][k] = tbl_win[i][k];
          tbl_next[wr] = tbl_next[i];
          tbl_fill[wr] = tbl_fill[i];
          wr++;
        end
      end
      tbl_used = wr;
      hit = -1;
      for (int i = 0; i < tbl_used; i++)
        if (tbl_sensor[i] == w.sensor) hit = i;
      if (hit < 0) begin
        r.status = ST_UNKNOWN;
      end else begin
        tbl_seen[hit] = w.stamp;
        tbl_win[hit][tbl_next[hit]] = w.temp;
        tbl_next[hit] = (tbl_next[hit] + 1) % WIN;
        if (tbl_fill[hit] < WIN) tbl_fill[hit]++;
        sum = 0;
        for (int k = 0; k < tbl_fill[hit]; k++) sum += int'(tbl_win[hit][k]);
        r.avg = 16'(sum / tbl_fill[hit]);
        r.room = tbl_room[hit];
        r.cold = $signed(r.avg) < lim_cold;
        r.hot = $signed(r.avg) > lim_hot;
        r.status = ST_UPDATED;
      end
    end
    return r;
  endfunction

  // Sender: a word is held until taken, then the next one is chosen.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        alarm_q.push_back(predict_alarm(sensor_word_t'(s_tdata[80:0])));
        n_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (hold_send || pending_q.size() == 0 || (!calm && $urandom_range(0, 99) < 25)) begin
          s_tvalid <= 1'b0;
        end else begin
          s_tvalid <= 1'b1;
          s_tdata <= {7'd0, pending_q.pop_front()};
        end
      end
    end
  end

  // Receiver and checker.
  always @(posedge clk) begin
    alarm_word_t got, exp_w;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || $urandom_range(0, 99) >= 25;
      if (m_tvalid && m_tready) begin
        got = alarm_word_t'(m_tdata[36:0]);
        n_recv++;
        status_seen[got.status]++;
        if (alarm_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) $display("unexpected result word %h", m_tdata);
        end else begin
          exp_w = alarm_q.pop_front();
          if (got.status !== exp_w.status || got.room !== exp_w.room ||
              got.avg !== exp_w.avg || got.cold !== exp_w.cold || got.hot !== exp_w.hot) begin
            n_bad++;
            if (n_bad <= 10)
              $display("mismatch #%0d: status %0d/%0d room %h/%h avg %h/%h cold %b/%b hot %b/%b",
                       n_recv, exp_w.status, got.status, exp_w.room, got.room,
                       exp_w.avg, got.avg, exp_w.cold, got.cold, exp_w.hot, got.hot);
          end
        end
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      REG_COLD: lim_cold = val;
      REG_HOT:  lim_hot = val;
      default:  lim_timeout = val;
    endcase
  endtask

  task automatic set_limits(logic [15:0] c, logic [15:0] h, logic [15:0] t);
    write_reg(REG_COLD, c);
    write_reg(REG_HOT, h);
    write_reg(REG_TIMEOUT, t);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || s_tvalid || alarm_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic sensor_word_t mk(bit c, int s, int rm, int tp, int unsigned st);
    sensor_word_t w;
    w.cmd = c;
    w.sensor = SENSOR_W'(s);
    w.room = ROOM_W'(rm);
    w.temp = TEMP_W'(tp);
    w.stamp = st;
    return w;
  endfunction

  logic [SENSOR_W-1:0] pool [16];
  int unsigned now_s = 1000;
  logic [SENSOR_W-1:0] gen_sensor;
  logic [STAMP_W-1:0]  gen_stamp;

  task automatic queue_random(int count);
    sensor_word_t w;
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      w = mk(1'b1, pool[$urandom_range(0, 15)], $urandom, 0, 0);
      w.temp = ($urandom_range(0, 9) < 7)
               ? TEMP_W'(16'h1500 + $urandom_range(0, 16'h0800) - 16'h0400)
               : TEMP_W'($urandom);
      if (r < 15) begin
        w.cmd = 1'b0;
      end else if (r < 20) begin
        w.cmd = 1'b0;
        w.sensor = SENSOR_W'($urandom);
      end else if (r < 28) begin
        w.sensor = gen_sensor;
        w.stamp = gen_stamp;
      end else begin
        if (r < 33) w.sensor = SENSOR_W'($urandom);
        r = $urandom_range(0, 99);
        if (r < 4) now_s = $urandom;
        else if (r < 10) now_s += lim_timeout + $urandom_range(1, 100);
        else now_s += $urandom_range(0, 5);
        w.stamp = now_s;
      end
      if (w.cmd) begin
        gen_sensor = w.sensor;
        gen_stamp = w.stamp;
      end
      pending_q.push_back(w);
    end
  endtask

  initial begin
    lim_cold = COLD_RESET;
    lim_hot = HOT_RESET;
    lim_timeout = TIMEOUT_RESET;
    tbl_used = 0;
    last_ok = 1'b0;
    last_sensor = '0;
    last_stamp = '0;
    foreach (status_seen[i]) status_seen[i] = 0;
    foreach (pool[i]) pool[i] = (i < 12) ? 16'($urandom_range(0, 40)) : 16'($urandom);
    pool[0] = 16'h0000;
    pool[1] = 16'hFFFF;
    gen_sensor = '0;
    gen_stamp = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: first measurement matching the reset sensor and stamp is not a
    // duplicate, then extremes, several entries for one sensor, unknown sensors.
    pending_q.push_back(mk(1'b0, 0, 0, 0, 0));
    pending_q.push_back(mk(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF));
    pending_q.push_back(mk(1'b1, 0, 0, 16'h7FFF, 0));
    pending_q.push_back(mk(1'b1, 0, 0, 16'h7FFF, 0));
    pending_q.push_back(mk(1'b0, 0, 16'h1234, 0, 0));
    pending_q.push_back(mk(1'b1, 0, 0, 16'h8000, 10));
    pending_q.push_back(mk(1'b1, 0, 0, 16'h8000, 11));
    pending_q.push_back(mk(1'b1, 16'hFFFF, 0, 16'h8000, 12));
    pending_q.push_back(mk(1'b1, 16'hFFFF, 0, 16'h7FFF, 13));
    pending_q.push_back(mk(1'b1, 16'h0007, 0, 16'h1000, 14));
    pending_q.push_back(mk(1'b1, 0, 0, 16'h1100, 15));
    pending_q.push_back(mk(1'b1, 0, 0, 16'h1800, 16));
    pending_q.push_back(mk(1'b1, 0, 0, 16'h2000, 17));
    pending_q.push_back(mk(1'b1, 0, 0, 16'hF000, 18));
    pending_q.push_back(mk(1'b1, 16'hFFFF, 0, 16'h1000, 32'hFFFFFFFF));
    pending_q.push_back(mk(1'b1, 0, 0, 16'h1000, 100));
    drain();

    set_limits(16'h8000, 16'h7FFF, 16'h0000);
    for (int i = 0; i < 35; i++) pending_q.push_back(mk(1'b0, pool[i % 16], $urandom, 0, 0));
    queue_random(165);
    drain();

    set_limits(16'h7FFF, 16'h8000, 16'hFFFF);
    queue_random(200);
    calm = 1'b1;
    while (pending_q.size() > 80) @(posedge clk);
    calm = 1'b0;
    hold_send = 1'b1;
    while (s_tvalid || alarm_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    hold_send = 1'b0;
    drain();

    set_limits(16'($urandom), 16'($urandom), 16'($urandom_range(0, 200)));
    queue_random(200);
    drain();

    set_limits(COLD_RESET, HOT_RESET, TIMEOUT_RESET);
    queue_random(200);
    drain();

    $display("%0d words sent, %0d results checked under five limit settings", n_sent, n_recv);
    $display("loaded %0d, full %0d, duplicate %0d, unknown %0d, updated %0d",
             status_seen[ST_LOADED], status_seen[ST_FULL], status_seen[ST_DUPLICATE],
             status_seen[ST_UNKNOWN], status_seen[ST_UPDATED]);
    if (n_bad == 0 && alarm_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout with %0d results outstanding", alarm_q.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
